// ===== design/binary_arithmetic_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// Binary arithmetic encoder assertion macros
// Shorthand for clocked implication checks used by the top level.
// ----------------------------------------------------------------------------
`ifndef BINARY_ARITHMETIC_ENCODER_DEFINES_SVH
`define BINARY_ARITHMETIC_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BAE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define BAE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/bae_pkg.sv =====
// ----------------------------------------------------------------------------
// bae_pkg
// Types, codes and constants shared by the binary arithmetic encoder modules.
// ----------------------------------------------------------------------------
package bae_pkg;

   localparam int COUNT_BITS_DEF   = 16;
   localparam int PENDING_BITS_DEF = 16;
   localparam int RANGE_SHIFT      = 31;
   localparam int MAX_RESULTS      = 20;
   localparam int IDX_W            = $clog2(MAX_RESULTS + 1);

   localparam logic [31:0] RANGE_RESET = 32'h8000_0000;
   localparam logic [31:0] FIN_MASK0   = 32'h7FFF_FFFF;
   localparam logic [31:0] FIN_MASK1   = 32'h3FFF_FFFF;
   localparam logic [15:0] LEN_MAX     = 16'hFFFF;

   // Error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_COUNTS   = 3'd1;
   localparam logic [2:0] ERR_SPLIT    = 3'd2;
   localparam logic [2:0] ERR_CARRY    = 3'd3;
   localparam logic [2:0] ERR_PENDING  = 3'd4;
   localparam logic [2:0] ERR_FINALIZE = 3'd5;

   // Command field of an input transaction
   localparam logic CMD_ENCODE   = 1'b0;
   localparam logic CMD_FINALIZE = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic        symbol_bit;
      logic [15:0] count_zero;
      logic [15:0] count_one;
   } req_type;

   typedef struct packed {
      logic        lead_valid;
      logic        lead_bit;
      logic        run_bit;
      logic [15:0] run_length;
      logic        last;
      logic [2:0]  error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_APPLY,
      ST_RENORM,
      ST_FCHK0,
      ST_FCHK1,
      ST_FCARRY,
      ST_FBIT,
      ST_FEMIT,
      ST_COMMIT,
      ST_SEND,
      ST_FAIL
   } ctl_state_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_CHECK,
      DP_DIV,
      DP_APPLY,
      DP_RENORM,
      DP_FCHK0,
      DP_FCHK1,
      DP_FCARRY,
      DP_FBIT,
      DP_FEMIT,
      DP_COMMIT,
      DP_SEND,
      DP_SEND_ERR
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] err;
      logic       div_done;
      logic       renorm_done;
      logic       fin_more;
      logic       fbit_last;
      logic       out_free;
      logic       send_last;
      logic       buf_empty;
   } dp_status_type;

   // Clamp a pending count to the run length field
   function automatic logic [15:0] sat_len(input logic [31:0] v);
      logic [15:0] r;
      r = (v > 32'(LEN_MAX)) ? LEN_MAX : v[15:0];
      return r;
   endfunction

endpackage

// ===== design/bae_ctrl.sv =====
// ----------------------------------------------------------------------------
// bae_ctrl
// Sequencer of the encoder: steps the datapath through split, renormalize,
// finalize, commit and result delivery.
// ----------------------------------------------------------------------------
module bae_ctrl
   import bae_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_cmd,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    dp_cmd
);

   ctl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_cmd == CMD_FINALIZE) ? ST_FCHK0 : ST_CHECK;
            end
         end
         ST_CHECK:  state_in = (status.err != ERR_NONE) ? ST_FAIL : ST_DIV;
         ST_DIV:    if (status.div_done) state_in = ST_APPLY;
         ST_APPLY:  state_in = (status.err != ERR_NONE) ? ST_FAIL : ST_RENORM;
         ST_RENORM: begin
            priority if (status.renorm_done) state_in = ST_COMMIT;
            else if (status.err != ERR_NONE) state_in = ST_FAIL;
         end
         ST_FCHK0:  state_in = status.fin_more ? ST_FCHK1 : ST_FCARRY;
         ST_FCHK1:  state_in = (status.err != ERR_NONE) ? ST_FAIL : ST_FCARRY;
         ST_FCARRY: state_in = (status.err != ERR_NONE) ? ST_FAIL : ST_FBIT;
         ST_FBIT: begin
            priority if (status.err != ERR_NONE) state_in = ST_FAIL;
            else if (status.fbit_last) state_in = ST_FEMIT;
         end
         ST_FEMIT:  state_in = (status.err != ERR_NONE) ? ST_FAIL : ST_COMMIT;
         ST_COMMIT: state_in = status.buf_empty ? ST_IDLE : ST_SEND;
         ST_SEND:   if (status.out_free && status.send_last) state_in = ST_IDLE;
         ST_FAIL:   if (status.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      dp_cmd    = DP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) dp_cmd = DP_LOAD;
         end
         ST_CHECK:  dp_cmd = DP_CHECK;
         ST_DIV:    dp_cmd = DP_DIV;
         ST_APPLY:  dp_cmd = DP_APPLY;
         ST_RENORM: if (!status.renorm_done) dp_cmd = DP_RENORM;
         ST_FCHK0:  dp_cmd = DP_FCHK0;
         ST_FCHK1:  dp_cmd = DP_FCHK1;
         ST_FCARRY: dp_cmd = DP_FCARRY;
         ST_FBIT:   dp_cmd = DP_FBIT;
         ST_FEMIT:  dp_cmd = DP_FEMIT;
         ST_COMMIT: dp_cmd = DP_COMMIT;
         ST_SEND:   if (status.out_free) dp_cmd = DP_SEND;
         ST_FAIL:   if (status.out_free) dp_cmd = DP_SEND_ERR;
         default:   dp_cmd = DP_NONE;
      endcase
   end

endmodule

// ===== design/bae_dpath.sv =====
// ----------------------------------------------------------------------------
// bae_dpath
// Encoder datapath: coder state, serial divider for the range split,
// emission logic, result buffer and output register.
// ----------------------------------------------------------------------------
module bae_dpath
   import bae_pkg::*;
#(
   parameter int COUNT_BITS   = COUNT_BITS_DEF,
   parameter int PENDING_BITS = PENDING_BITS_DEF
)
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    dp_cmd,
   input  req_type       req_data,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);

   localparam int PROD_W = 32 + COUNT_BITS;
   localparam int CNT_W  = $clog2(PROD_W);
   localparam logic [PENDING_BITS-1:0] OP_MAX = {PENDING_BITS{1'b1}};

   // Committed coder state
   logic [31:0]             low_ff, rng_ff;
   logic                    zp_ff;
   logic [PENDING_BITS-1:0] op_ff;
   // Working copy for the transaction in flight
   logic [31:0]             wl_ff, wr_ff;
   logic                    wzp_ff;
   logic [PENDING_BITS-1:0] wop_ff;
   logic [COUNT_BITS-1:0]   c0_ff, c1_ff;
   logic                    bit_ff;
   // Divider
   logic [PROD_W-1:0]       dvd_ff;
   logic [COUNT_BITS:0]     dsr_ff, rem_ff;
   logic [CNT_W-1:0]        cnt_ff;
   // Finalize
   logic [31:0]             ft_ff;
   logic                    fcy_ff, fnb_ff, fi_ff;
   // Result buffer and output
   rsp_type                 buf_mem [MAX_RESULTS];
   logic [IDX_W-1:0]        n_ff, rd_ff;
   logic [2:0]              err_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;

   // Emission candidates from the working pending state
   rsp_type                 e0_ent, e1_ent, ent;
   logic                    e0_put, put;
   logic [PENDING_BITS-1:0] op_m1;
   logic                    zp_nx;
   logic [PENDING_BITS-1:0] op_nx;
   logic [2:0]              step_err;
   logic [32:0]             sum_lo;
   logic [31:0]             q, fin_t, fin_d;
   logic [COUNT_BITS+1:0]   trial;
   logic                    fin_cond;
   logic [31:0]             fin_m;

   // Mark a buffered emission as the last of its transaction
   function automatic rsp_type mark_last(input rsp_type e, input logic l);
      rsp_type r;
      r      = e;
      r.last = l;
      return r;
   endfunction

   assign op_m1 = wop_ff - PENDING_BITS'(1);

   always_comb begin
      e0_ent            = '0;
      e0_ent.lead_valid = wzp_ff;
      e0_ent.run_bit    = 1'b1;
      e0_ent.run_length = sat_len(32'(wop_ff));
      e0_put            = wzp_ff || (wop_ff != '0);
      e1_ent            = '0;
      e1_ent.lead_valid = 1'b1;
      e1_ent.lead_bit   = 1'b1;
      e1_ent.run_length = (wop_ff > PENDING_BITS'(1)) ? sat_len(32'(op_m1)) : '0;
   end

   // Finalize tolerance check for the current mask
   assign fin_m    = (dp_cmd == DP_FCHK1) ? FIN_MASK1 : FIN_MASK0;
   assign fin_t    = wl_ff + fin_m;
   assign fin_d    = (fin_t | fin_m) - wl_ff;
   assign fin_cond = fin_d >= wr_ff;

   assign q      = dvd_ff[31:0];
   assign sum_lo = {1'b0, wl_ff} + {1'b0, q};
   assign trial  = {rem_ff, dvd_ff[PROD_W-1]} - {1'b0, dsr_ff};

   // Pick the pending update and error for this step
   always_comb begin
      step_err = ERR_NONE;
      put      = 1'b0;
      ent      = e0_ent;
      zp_nx    = wzp_ff;
      op_nx    = wop_ff;
      unique case (dp_cmd)
         DP_CHECK: begin
            if (c0_ff == '0 || c1_ff == '0) step_err = ERR_COUNTS;
         end
         DP_APPLY: begin
            priority if (q == '0 || q >= wr_ff) begin
               step_err = ERR_SPLIT;
            end else if (!bit_ff && sum_lo[32]) begin
               if (!wzp_ff) step_err = ERR_CARRY;
               put   = 1'b1;
               ent   = e1_ent;
               zp_nx = wop_ff != '0;
               op_nx = '0;
            end
         end
         DP_FCHK1: begin
            if (fin_cond) step_err = ERR_FINALIZE;
         end
         DP_FCARRY: begin
            if (fcy_ff) begin
               if (!wzp_ff) step_err = ERR_CARRY;
               put   = 1'b1;
               ent   = e1_ent;
               zp_nx = wop_ff != '0;
               op_nx = '0;
            end
         end
         DP_RENORM, DP_FBIT: begin
            if ((dp_cmd == DP_RENORM) ? wl_ff[RANGE_SHIFT]
                                      : ft_ff[RANGE_SHIFT - 32'(fi_ff)]) begin
               if (wop_ff == OP_MAX) step_err = ERR_PENDING;
               op_nx = wop_ff + PENDING_BITS'(1);
            end else begin
               put   = e0_put;
               zp_nx = 1'b1;
               op_nx = '0;
            end
         end
         DP_FEMIT: begin
            put   = e0_put;
            zp_nx = 1'b1;
            op_nx = '0;
         end
         default: begin
            step_err = ERR_NONE;
         end
      endcase
   end

   // Coder state, divider and finalize registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff <= '0;
         rng_ff <= RANGE_RESET;
         zp_ff  <= 1'b0;
         op_ff  <= '0;
         n_ff   <= '0;
         rd_ff  <= '0;
         err_ff <= ERR_NONE;
      end else begin
         if (step_err != ERR_NONE) err_ff <= step_err;
         if (step_err == ERR_NONE && dp_cmd != DP_LOAD) begin
            wzp_ff <= zp_nx;
            wop_ff <= op_nx;
            if (put && n_ff < IDX_W'(MAX_RESULTS)) begin
               buf_mem[n_ff] <= ent;
               n_ff          <= n_ff + IDX_W'(1);
            end
         end
         unique case (dp_cmd)
            DP_LOAD: begin
               wl_ff  <= low_ff;
               wr_ff  <= rng_ff;
               wzp_ff <= zp_ff;
               wop_ff <= op_ff;
               c0_ff  <= COUNT_BITS'(32'(req_data.count_zero));
               c1_ff  <= COUNT_BITS'(32'(req_data.count_one));
               bit_ff <= req_data.symbol_bit;
               n_ff   <= '0;
               rd_ff  <= '0;
               err_ff <= ERR_NONE;
            end
            DP_CHECK: begin
               dvd_ff <= PROD_W'(wr_ff) * PROD_W'(c1_ff);
               dsr_ff <= {1'b0, c0_ff} + {1'b0, c1_ff};
               rem_ff <= '0;
               cnt_ff <= '0;
            end
            DP_DIV: begin
               // Restoring step: one quotient bit per cycle
               if (!trial[COUNT_BITS+1]) begin
                  rem_ff <= trial[COUNT_BITS:0];
                  dvd_ff <= {dvd_ff[PROD_W-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[COUNT_BITS-1:0], dvd_ff[PROD_W-1]};
                  dvd_ff <= {dvd_ff[PROD_W-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
            DP_APPLY: begin
               if (bit_ff) begin
                  wr_ff <= q;
               end else begin
                  wr_ff <= wr_ff - q;
                  wl_ff <= sum_lo[31:0];
               end
            end
            DP_RENORM: begin
               wl_ff <= {wl_ff[30:0], 1'b0};
               wr_ff <= {wr_ff[30:0], 1'b0};
            end
            DP_FCHK0, DP_FCHK1: begin
               ft_ff  <= fin_t;
               fcy_ff <= fin_m > ~wl_ff;
               fnb_ff <= dp_cmd == DP_FCHK1;
               fi_ff  <= 1'b0;
            end
            DP_FBIT: fi_ff <= 1'b1;
            DP_COMMIT: begin
               low_ff <= wl_ff;
               rng_ff <= wr_ff;
               zp_ff  <= wzp_ff;
               op_ff  <= wop_ff;
            end
            DP_SEND: rd_ff <= rd_ff + IDX_W'(1);
            default: begin
               rd_ff <= rd_ff;
            end
         endcase
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         priority if (dp_cmd == DP_SEND) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= mark_last(buf_mem[rd_ff], rd_ff == n_ff - IDX_W'(1));
         end else if (dp_cmd == DP_SEND_ERR) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= '{last: 1'b1, error: err_ff, default: '0};
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      status             = '0;
      status.err         = step_err;
      status.div_done    = cnt_ff == CNT_W'(PROD_W - 1);
      status.renorm_done = wr_ff[RANGE_SHIFT];
      status.fin_more    = fin_cond;
      status.fbit_last   = fi_ff == fnb_ff;
      status.out_free    = !rsp_valid_ff || rsp_ready;
      status.send_last   = rd_ff == n_ff - IDX_W'(1);
      status.buf_empty   = n_ff == '0;
   end

endmodule

// ===== design/binary_arithmetic_encoder.sv =====
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder
// Top level: binary arithmetic encoder with 32-bit low and range.
// ----------------------------------------------------------------------------
// One transaction at a time. An encode loads the request, checks the counts,
// forms the split (one multiply, then a restoring divider giving one quotient
// bit a cycle), applies it, renormalizes by shifting low and range left until
// range bit 31 is set, commits, and delivers each result while the output is
// free. A finalize runs one or two tolerance checks, a carry step, one or two
// bit steps, a flush and a commit. Results of a transaction are buffered and
// released only after the whole transaction succeeds; an error yields a single
// result with last set and state unchanged.
`include "binary_arithmetic_encoder_defines.svh"

module binary_arithmetic_encoder
   import bae_pkg::*;
#(
   parameter int COUNT_BITS   = COUNT_BITS_DEF,
   parameter int PENDING_BITS = PENDING_BITS_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type status;

   // Sequencer
   bae_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_ready (req_ready),
      .status    (status),
      .dp_cmd    (dp_cmd)
   );

   // Datapath
   bae_dpath #(
      .COUNT_BITS   (COUNT_BITS),
      .PENDING_BITS (PENDING_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Checks
   `BAE_ASSERT_SAME(a_err_last, clock, reset, rsp_valid && rsp_data.error != ERR_NONE, rsp_data.last, "error result without last")
   `BAE_ASSERT_SAME(a_err_clean, clock, reset, rsp_valid && rsp_data.error != ERR_NONE, !rsp_data.lead_valid && rsp_data.run_length == '0, "error result carries payload")
   `BAE_ASSERT_NEXT(a_one_at_time, clock, reset, req_valid && req_ready, !req_ready, "second transaction taken while busy")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary arithmetic encoder. Directed and random
// encode/finalize transactions are driven through the request channel; an
// in-bench coder model predicts every emission and the scoreboard checks
// each response field by field, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import bae_pkg::*;

   localparam int CLK_HALF   = 4;
   localparam int N_RANDOM   = 460;
   localparam int DRAIN_CYC  = 300;
   localparam int PEND_LIMIT = 65535;

   // Coder model plus queue of expected emissions
   class coder_scoreboard;
      logic [31:0] low_q, range_q, ones_q;
      logic        zero_q;
      logic [31:0] w_low, w_range, w_ones;
      logic        w_zero;
      rsp_type     emitted[$];
      rsp_type     expected_rsp[$];
      int          errors, n_req, n_rsp, n_fin;

      function new();
         low_q   = 32'd0;
         range_q = RANGE_RESET;
         zero_q  = 1'b0;
         ones_q  = 32'd0;
         errors  = 0;
         n_req   = 0;
         n_rsp   = 0;
         n_fin   = 0;
      endfunction

      task report(input string msg);
         errors++;
         $display("MISMATCH @%0t: %s", $realtime, msg);
      endtask

      function void push_emit(logic lv, logic lb, logic rb, logic [31:0] len);
         rsp_type r;
         r = '0;
         r.lead_valid = lv;
         r.lead_bit   = lb;
         r.run_bit    = rb;
         r.run_length = (len > 32'(LEN_MAX)) ? LEN_MAX : len[15:0];
         if (emitted.size() < MAX_RESULTS) emitted.push_back(r);
      endfunction

      // Settle a zero (flush pending ones) or propagate a carry
      function logic [2:0] settle(logic carry);
         if (!carry) begin
            if (w_zero || w_ones > 0) push_emit(w_zero, 1'b0, 1'b1, w_ones);
            w_ones = 0;
            w_zero = 1'b1;
         end else begin
            if (!w_zero) return ERR_CARRY;
            push_emit(1'b1, 1'b1, 1'b0, (w_ones > 1) ? w_ones - 1 : 32'd0);
            w_zero = (w_ones > 0);
            w_ones = 0;
         end
         return ERR_NONE;
      endfunction

      function logic [2:0] hold_one();
         if (w_ones + 1 > PEND_LIMIT) return ERR_PENDING;
         w_ones++;
         return ERR_NONE;
      endfunction

      function logic [2:0] code_bit(logic bit_v, logic [15:0] c0, logic [15:0] c1);
         logic [63:0] split;
         logic [31:0] sp;
         logic [2:0]  e;
         int          k;
         if (c0 == 0 || c1 == 0) return ERR_COUNTS;
         split = (64'(w_range) * 64'(c1)) / (64'(c0) + 64'(c1));
         if (split == 0 || split >= 64'(w_range)) return ERR_SPLIT;
         sp = split[31:0];
         if (bit_v) begin
            w_range = sp;
         end else begin
            w_range = w_range - sp;
            if (sp > ~w_low) begin
               e = settle(1'b1);
               if (e != ERR_NONE) return e;
            end
            w_low = w_low + sp;
         end
         for (k = 0; k < 32 && w_range < RANGE_RESET; k++) begin
            if (w_low[RANGE_SHIFT]) e = hold_one();
            else e = settle(1'b0);
            if (e != ERR_NONE) return e;
            w_low   = w_low << 1;
            w_range = w_range << 1;
         end
         return ERR_NONE;
      endfunction

      function logic [2:0] flush_stream();
         logic [31:0] m, lo;
         logic [2:0]  e;
         int          nb, i;
         m  = FIN_MASK0;
         lo = w_low;
         nb = 1;
         while (m != 0 && (((lo + m) | m) - lo) >= w_range) begin
            nb++;
            m = m >> 1;
         end
         if (nb > 2) return ERR_FINALIZE;
         if (m > ~lo) begin
            e = settle(1'b1);
            if (e != ERR_NONE) return e;
         end
         for (i = 0; i < nb; i++) begin
            if (((lo + m) & (RANGE_RESET >> i)) != 0) e = hold_one();
            else e = settle(1'b0);
            if (e != ERR_NONE) return e;
         end
         return settle(1'b0);
      endfunction

      // Predict the emissions of one accepted request
      function void note_request(req_type q);
         logic [2:0] e;
         rsp_type    r;
         n_req++;
         w_low   = low_q;
         w_range = range_q;
         w_zero  = zero_q;
         w_ones  = ones_q;
         emitted.delete();
         if (q.cmd == CMD_FINALIZE) begin
            n_fin++;
            e = flush_stream();
         end else begin
            e = code_bit(q.symbol_bit, q.count_zero, q.count_one);
         end
         if (e != ERR_NONE) begin
            r = '0;
            r.last  = 1'b1;
            r.error = e;
            expected_rsp.push_back(r);
            return;
         end
         low_q   = w_low;
         range_q = w_range;
         zero_q  = w_zero;
         ones_q  = w_ones;
         if (emitted.size() > 0) emitted[emitted.size() - 1].last = 1'b1;
         foreach (emitted[i]) expected_rsp.push_back(emitted[i]);
      endfunction

      task check_response(rsp_type got);
         rsp_type exp_r;
         n_rsp++;
         if (expected_rsp.size() == 0) begin
            report($sformatf("unexpected response %p", got));
            return;
         end
         exp_r = expected_rsp.pop_front();
         if (got.lead_valid !== exp_r.lead_valid)
            report($sformatf("lead_valid %b exp %b", got.lead_valid, exp_r.lead_valid));
         if (got.lead_bit !== exp_r.lead_bit)
            report($sformatf("lead_bit %b exp %b", got.lead_bit, exp_r.lead_bit));
         if (got.run_bit !== exp_r.run_bit)
            report($sformatf("run_bit %b exp %b", got.run_bit, exp_r.run_bit));
         if (got.run_length !== exp_r.run_length)
            report($sformatf("run_length %0d exp %0d", got.run_length, exp_r.run_length));
         if (got.last !== exp_r.last)
            report($sformatf("last %b exp %b", got.last, exp_r.last));
         if (got.error !== exp_r.error)
            report($sformatf("error %0d exp %0d", got.error, exp_r.error));
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   coder_scoreboard sb = new();
   bit quiet = 1'b0;
   int rsp_stall = 0;

   always #(CLK_HALF) clock = ~clock;

   binary_arithmetic_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Monitor both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      end
   end

   // Stall the response channel in random bursts
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_ready = 1'b0;
         rsp_stall--;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
         rsp_ready = 1'b0;
         rsp_stall = $urandom_range(1, 18) - 1;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // Drive one request transaction, with an optional idle burst first
   task send_req(input req_type q);
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task send_code(input logic b, input logic [15:0] c0, input logic [15:0] c1);
      req_type q;
      q = '0;
      q.cmd        = CMD_ENCODE;
      q.symbol_bit = b;
      q.count_zero = c0;
      q.count_one  = c1;
      send_req(q);
   endtask

   task send_flush();
      req_type q;
      q = '0;
      q.cmd = CMD_FINALIZE;
      q.symbol_bit = 1'($urandom_range(0, 1));
      q.count_zero = 16'($urandom);
      q.count_one  = 16'($urandom);
      send_req(q);
   endtask

   // Pick a nonzero count, skewed toward the extremes now and then
   function logic [15:0] pick_count();
      case ($urandom_range(0, 5))
         0: return 16'd1;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1, 16));
         default: return 16'($urandom_range(1, 65535));
      endcase
   endfunction

   initial begin
      int n, len, i;
      req_type q;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: finalize from reset, bad counts, count extremes
      send_flush();
      send_code(1'b0, 16'd0, 16'd5);
      send_code(1'b1, 16'd5, 16'd0);
      send_code(1'b0, 16'd0, 16'd0);
      send_code(1'b1, 16'd1, 16'd1);
      send_code(1'b0, 16'hFFFF, 16'd1);
      send_code(1'b0, 16'hFFFF, 16'd1);
      send_code(1'b1, 16'hFFFF, 16'd1);
      send_code(1'b1, 16'd1, 16'hFFFF);
      send_code(1'b0, 16'd1, 16'hFFFF);
      send_code(1'b0, 16'd1, 16'hFFFF);
      send_code(1'b1, 16'hFFFF, 16'hFFFF);
      send_code(1'b0, 16'hFFFF, 16'hFFFF);
      send_flush();
      send_flush();
      send_code(1'b1, 16'h5555, 16'hAAAA);
      send_code(1'b0, 16'hAAAA, 16'h5555);
      send_flush();

      // Random: mostly well-formed streams, some noise
      n = 0;
      while (n < N_RANDOM) begin
         if (n > N_RANDOM - 60) quiet = 1'b1;
         if ($urandom_range(0, 9) == 0) begin
            q = req_type'($bits(req_type)'({$urandom, $urandom}));
            if ($urandom_range(0, 1) == 0) q.count_zero = 16'd0;
            else if ($urandom_range(0, 1) == 0) q.count_one = 16'd0;
            send_req(q);
            n++;
         end else begin
            send_code(1'b1, pick_count(), pick_count());
            len = $urandom_range(1, 30);
            for (i = 0; i < len; i++)
               send_code(1'($urandom_range(0, 1)), pick_count(), pick_count());
            send_flush();
            n += len + 2;
         end
      end
      @(negedge clock);
      req_valid = 1'b0;

      // Drain
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      $display("Covered %0d requests (%0d finalize), %0d responses checked",
               sb.n_req, sb.n_fin, sb.n_rsp);
      if (sb.errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20ms;
      $display("Timeout with %0d responses outstanding", sb.expected_rsp.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
